### rtl/bfc_pkg.sv
// ----------------------------------------------------------------------------
// bfc_pkg
// Shared constants, codes and controller/datapath interface types for the
// box versus frustum corner test.
// ----------------------------------------------------------------------------
package bfc_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int NUM_PLANES    = 6;
    localparam int NUM_CORNERS   = 8;
    localparam int NUM_ROWS      = 3;

    localparam logic [1:0] CMD_LOAD_PLANE = 2'd0;
    localparam logic [1:0] CMD_LOAD_ROW   = 2'd1;
    localparam logic [1:0] CMD_TEST       = 2'd2;

    // Controller commands to the datapath
    typedef struct packed {
        logic       latch;      // capture box corners
        logic       xf_mul;     // transform row products for row xf_row
        logic [1:0] xf_row;
        logic       xf_acc;     // reduce transform row products
        logic       pl_mul;     // plane products for plane pl_idx
        logic [2:0] pl_idx;
        logic       pl_acc;     // reduce plane products, update behind mask
        logic [2:0] corner;
        logic       clr_mask;
    } bfc_cmd_t;

    typedef struct packed {
        logic visible;
    } bfc_stat_t;

endpackage

### rtl/bfc_ctrl.sv
// ----------------------------------------------------------------------------
// bfc_ctrl
// Sequencer: per corner, three transform rows then six planes, each as a
// multiply step followed by an accumulate step.
// ----------------------------------------------------------------------------
module bfc_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               go,
    output logic               busy,
    output logic               done,
    output bfc_pkg::bfc_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_XF   = 2'd1;
    localparam logic [1:0] ST_PL   = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [2:0] corner_reg, corner_next;
    logic [2:0] idx_reg, idx_next;
    logic       phase_reg, phase_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            corner_reg <= '0;
            idx_reg    <= '0;
            phase_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            corner_reg <= corner_next;
            idx_reg    <= idx_next;
            phase_reg  <= phase_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        corner_next = corner_reg;
        idx_next    = idx_reg;
        phase_next  = phase_reg;
        cmd         = '0;
        cmd.corner  = corner_reg;
        cmd.xf_row  = idx_reg[1:0];
        cmd.pl_idx  = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (go)
                begin
                    cmd.latch    = 1'b1;
                    cmd.clr_mask = 1'b1;
                    state_next   = ST_XF;
                    corner_next  = '0;
                    idx_next     = '0;
                    phase_next   = 1'b0;
                end
            end
            ST_XF:
            begin
                phase_next = !phase_reg;
                if (!phase_reg)
                    cmd.xf_mul = 1'b1;
                else
                begin
                    cmd.xf_acc = 1'b1;
                    if (idx_reg == 3'(bfc_pkg::NUM_ROWS - 1))
                    begin
                        idx_next   = '0;
                        state_next = ST_PL;
                    end
                    else
                        idx_next = idx_reg + 3'd1;
                end
            end
            ST_PL:
            begin
                phase_next = !phase_reg;
                if (!phase_reg)
                    cmd.pl_mul = 1'b1;
                else
                begin
                    cmd.pl_acc = 1'b1;
                    if (idx_reg == 3'(bfc_pkg::NUM_PLANES - 1))
                    begin
                        idx_next = '0;
                        if (corner_reg == 3'(bfc_pkg::NUM_CORNERS - 1))
                            state_next = ST_DONE;
                        else
                        begin
                            corner_next = corner_reg + 3'd1;
                            state_next  = ST_XF;
                        end
                    end
                    else
                        idx_next = idx_reg + 3'd1;
                end
            end
            ST_DONE:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);

    a_idle_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !phase_reg)
        else $error("phase set while idle");
    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (state_reg == ST_IDLE))
        else $error("done held");
    a_go_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (go && !busy) |=> (state_reg == ST_XF))
        else $error("start not taken");

endmodule

### rtl/bfc_dp.sv
// ----------------------------------------------------------------------------
// bfc_dp
// Datapath: plane and transform stores, three shared 32x32 multipliers with
// registered products, exact wide accumulation, saturation and behind mask.
// ----------------------------------------------------------------------------
module bfc_dp
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [1:0]         command,
    input  logic [2:0]         slot,
    input  logic signed [31:0] first_x,
    input  logic signed [31:0] first_y,
    input  logic signed [31:0] first_z,
    input  logic signed [31:0] fourth,
    input  logic signed [31:0] second_x,
    input  logic signed [31:0] second_y,
    input  logic signed [31:0] second_z,
    input  bfc_pkg::bfc_cmd_t  cmd,
    output bfc_pkg::bfc_stat_t stat
);

    localparam int F = bfc_pkg::FRACTION_BITS;

    logic signed [31:0] pnx_reg [bfc_pkg::NUM_PLANES];
    logic signed [31:0] pny_reg [bfc_pkg::NUM_PLANES];
    logic signed [31:0] pnz_reg [bfc_pkg::NUM_PLANES];
    logic signed [31:0] pd_reg  [bfc_pkg::NUM_PLANES];
    logic signed [31:0] tc_reg  [4*bfc_pkg::NUM_ROWS];

    logic signed [31:0] minx_reg, miny_reg, minz_reg;
    logic signed [31:0] maxx_reg, maxy_reg, maxz_reg;
    logic signed [31:0] w_reg [bfc_pkg::NUM_ROWS];
    logic signed [63:0] p0_reg, p1_reg, p2_reg;
    logic signed [32:0] add_reg;
    logic [1:0]         row_reg;
    logic [2:0]         pidx_reg;
    logic [bfc_pkg::NUM_PLANES-1:0] behind_reg;

    logic signed [31:0] lx, ly, lz, ma0, ma1, ma2, mb0, mb1, mb2;
    logic signed [65:0] sum;
    logic signed [65:0] fl;
    logic signed [66:0] xf;
    logic signed [66:0] pl_dist;
    logic signed [31:0] sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < bfc_pkg::NUM_PLANES; i++)
            begin
                pnx_reg[i] <= '0;
                pny_reg[i] <= '0;
                pnz_reg[i] <= '0;
                pd_reg[i]  <= '0;
            end
            for (int i = 0; i < 4*bfc_pkg::NUM_ROWS; i++)
                tc_reg[i] <= ((i % 5) == 0 && i < 12) ? 32'sd1 <<< F : '0;
            behind_reg <= '0;
        end
        else
        begin
            if (accept && command == bfc_pkg::CMD_LOAD_PLANE
                && slot < 3'(bfc_pkg::NUM_PLANES))
            begin
                pnx_reg[slot] <= first_x;
                pny_reg[slot] <= first_y;
                pnz_reg[slot] <= first_z;
                pd_reg[slot]  <= fourth;
            end
            if (accept && command == bfc_pkg::CMD_LOAD_ROW
                && slot < 3'(bfc_pkg::NUM_ROWS))
            begin
                tc_reg[{slot[1:0], 2'd0}] <= first_x;
                tc_reg[{slot[1:0], 2'd1}] <= first_y;
                tc_reg[{slot[1:0], 2'd2}] <= first_z;
                tc_reg[{slot[1:0], 2'd3}] <= fourth;
            end
            if (cmd.clr_mask)
                behind_reg <= '1;
            else if (cmd.pl_acc && pl_dist >= 0)
                behind_reg[pidx_reg] <= 1'b0;
        end
    end

    assign lx = cmd.corner[0] ? maxx_reg : minx_reg;
    assign ly = cmd.corner[1] ? maxy_reg : miny_reg;
    assign lz = cmd.corner[2] ? maxz_reg : minz_reg;

    always_comb
    begin
        if (cmd.pl_mul)
        begin
            ma0 = pnx_reg[cmd.pl_idx];
            ma1 = pny_reg[cmd.pl_idx];
            ma2 = pnz_reg[cmd.pl_idx];
            mb0 = w_reg[0];
            mb1 = w_reg[1];
            mb2 = w_reg[2];
        end
        else
        begin
            ma0 = tc_reg[{cmd.xf_row, 2'd0}];
            ma1 = tc_reg[{cmd.xf_row, 2'd1}];
            ma2 = tc_reg[{cmd.xf_row, 2'd2}];
            mb0 = lx;
            mb1 = ly;
            mb2 = lz;
        end
    end

    assign sum     = 66'(p0_reg) + 66'(p1_reg) + 66'(p2_reg);
    assign fl      = sum >>> F;
    assign xf      = 67'(fl) + 67'(add_reg);
    assign pl_dist = xf;
    assign sat     = (xf > 67'sd2147483647) ? 32'sh7fffffff :
                     (xf < -67'sd2147483648) ? 32'sh80000000 : xf[31:0];

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            minx_reg <= first_x;
            miny_reg <= first_y;
            minz_reg <= first_z;
            maxx_reg <= second_x;
            maxy_reg <= second_y;
            maxz_reg <= second_z;
        end
        if (cmd.xf_mul || cmd.pl_mul)
        begin
            p0_reg   <= ma0 * mb0;
            p1_reg   <= ma1 * mb1;
            p2_reg   <= ma2 * mb2;
            add_reg  <= cmd.pl_mul ? -33'(pd_reg[cmd.pl_idx])
                                   : 33'(tc_reg[{cmd.xf_row, 2'd3}]);
            row_reg  <= cmd.xf_row;
            pidx_reg <= cmd.pl_idx;
        end
        if (cmd.xf_acc)
            w_reg[row_reg] <= sat;
    end

    assign stat.visible = ~|behind_reg;

endmodule

### rtl/box_frustum_cull_test.sv
// ----------------------------------------------------------------------------
// box_frustum_cull_test
// Culls an axis-aligned box against six stored frustum planes after an
// affine transform of its eight corners, in Q16.16 fixed point.
//
// Usage: drive command, slot and the payload ports and raise start while
// busy is low; the request is taken at that edge. Plane loads (command 0)
// and transform row loads (command 1) take effect at once and give no
// result. A box test (command 2) walks 8 corners; for each corner it
// runs the three transform rows and then the six planes, each as a
// multiply step and an accumulate step on three shared 32x32
// multipliers, then enters a done state. done is high for exactly one
// cycle, in that done state, and visible is valid with it; busy drops
// after that cycle, so a new request is taken only once the test ends.
// The receiver cannot stall. Reset clears planes to zero (all visible)
// and loads the identity transform.
// ----------------------------------------------------------------------------
module box_frustum_cull_test
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         command,
    input  logic [2:0]         slot,
    input  logic signed [31:0] first_x,
    input  logic signed [31:0] first_y,
    input  logic signed [31:0] first_z,
    input  logic signed [31:0] fourth,
    input  logic signed [31:0] second_x,
    input  logic signed [31:0] second_y,
    input  logic signed [31:0] second_z,
    output logic               done,
    output logic               visible
);

    bfc_pkg::bfc_cmd_t  cmd;
    bfc_pkg::bfc_stat_t stat;
    logic accept;

    assign accept = start && !busy;

    bfc_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (accept && command == bfc_pkg::CMD_TEST),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    bfc_dp u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .command  (command),
        .slot     (slot),
        .first_x  (first_x),
        .first_y  (first_y),
        .first_z  (first_z),
        .fourth   (fourth),
        .second_x (second_x),
        .second_y (second_y),
        .second_z (second_z),
        .cmd      (cmd),
        .stat     (stat)
    );

    assign visible = stat.visible;

endmodule

### sim/box_frustum_cull_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_frustum_cull_checker
// Watches the request and result ports of the box culling block. It keeps its
// own copy of the plane and transform stores, works out the visible flag for
// every box test request, and compares each done strobe with the oldest
// expected flag.
// ----------------------------------------------------------------------------
module box_frustum_cull_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [1:0]         command,
    input  logic [2:0]         slot,
    input  logic signed [31:0] first_x,
    input  logic signed [31:0] first_y,
    input  logic signed [31:0] first_z,
    input  logic signed [31:0] fourth,
    input  logic signed [31:0] second_x,
    input  logic signed [31:0] second_y,
    input  logic signed [31:0] second_z,
    input  logic               done,
    input  logic               visible,
    output int                 fails,
    output int                 pending
);

    logic signed [31:0] norm_x [bfc_pkg::NUM_PLANES];
    logic signed [31:0] norm_y [bfc_pkg::NUM_PLANES];
    logic signed [31:0] norm_z [bfc_pkg::NUM_PLANES];
    logic signed [31:0] offset [bfc_pkg::NUM_PLANES];
    logic signed [31:0] xf     [4*bfc_pkg::NUM_ROWS];
    logic               visible_q [$];

    function automatic logic signed [79:0] wide(input logic signed [31:0] v);
        logic signed [79:0] w;
        w = v;
        return w;
    endfunction

    function automatic logic signed [31:0] xform_coord(input int r,
        input logic signed [31:0] px, input logic signed [31:0] py,
        input logic signed [31:0] pz);
        logic signed [79:0] acc;
        acc = wide(xf[4*r]) * wide(px) + wide(xf[4*r+1]) * wide(py)
            + wide(xf[4*r+2]) * wide(pz);
        acc = (acc >>> bfc_pkg::FRACTION_BITS) + wide(xf[4*r+3]);
        if (acc > wide(32'sh7fffffff))
            return 32'sh7fffffff;
        if (acc < wide(32'sh80000000))
            return 32'sh80000000;
        return acc[31:0];
    endfunction

    function automatic logic box_visible(
        input logic signed [31:0] ax, input logic signed [31:0] ay,
        input logic signed [31:0] az, input logic signed [31:0] bx,
        input logic signed [31:0] by, input logic signed [31:0] bz);
        logic signed [31:0] wx [bfc_pkg::NUM_CORNERS];
        logic signed [31:0] wy [bfc_pkg::NUM_CORNERS];
        logic signed [31:0] wz [bfc_pkg::NUM_CORNERS];
        logic signed [31:0] lx, ly, lz;
        logic signed [79:0] pl_dist;
        int                 behind;
        logic               vis;
        vis = 1'b1;
        for (int c = 0; c < bfc_pkg::NUM_CORNERS; c++)
        begin
            lx = c[0] ? bx : ax;
            ly = c[1] ? by : ay;
            lz = c[2] ? bz : az;
            wx[c] = xform_coord(0, lx, ly, lz);
            wy[c] = xform_coord(1, lx, ly, lz);
            wz[c] = xform_coord(2, lx, ly, lz);
        end
        for (int p = 0; p < bfc_pkg::NUM_PLANES; p++)
        begin
            behind = 0;
            for (int c = 0; c < bfc_pkg::NUM_CORNERS; c++)
            begin
                pl_dist = wide(norm_x[p]) * wide(wx[c]) + wide(norm_y[p]) * wide(wy[c])
                        + wide(norm_z[p]) * wide(wz[c])
                        - (wide(offset[p]) <<< bfc_pkg::FRACTION_BITS);
                if (pl_dist < 0)
                    behind++;
            end
            if (behind == bfc_pkg::NUM_CORNERS)
                vis = 1'b0;
        end
        return vis;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < bfc_pkg::NUM_PLANES; i++)
            begin
                norm_x[i] = '0;
                norm_y[i] = '0;
                norm_z[i] = '0;
                offset[i] = '0;
            end
            for (int i = 0; i < 4*bfc_pkg::NUM_ROWS; i++)
                xf[i] = '0;
            for (int i = 0; i < bfc_pkg::NUM_ROWS; i++)
                xf[4*i+i] = 32'sd1 <<< bfc_pkg::FRACTION_BITS;
            visible_q.delete();
            fails   = 0;
            pending = 0;
        end
        else
        begin
            if (done)
            begin
                if (visible_q.size() == 0)
                begin
                    $display("%0t: result with no request waiting, visible=%0b",
                             $time, visible);
                    fails++;
                end
                else
                begin
                    if (visible !== visible_q[0])
                    begin
                        $display("%0t: visible mismatch expected=%0b actual=%0b",
                                 $time, visible_q[0], visible);
                        fails++;
                    end
                    void'(visible_q.pop_front());
                end
            end
            if (start && !busy)
            begin
                if (command == bfc_pkg::CMD_LOAD_PLANE && slot < bfc_pkg::NUM_PLANES)
                begin
                    norm_x[slot] = first_x;
                    norm_y[slot] = first_y;
                    norm_z[slot] = first_z;
                    offset[slot] = fourth;
                end
                else if (command == bfc_pkg::CMD_LOAD_ROW && slot < bfc_pkg::NUM_ROWS)
                begin
                    xf[4*slot]   = first_x;
                    xf[4*slot+1] = first_y;
                    xf[4*slot+2] = first_z;
                    xf[4*slot+3] = fourth;
                end
                else if (command == bfc_pkg::CMD_TEST)
                    visible_q.push_back(box_visible(first_x, first_y, first_z,
                                                    second_x, second_y, second_z));
            end
            pending = visible_q.size();
        end
    end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives plane loads, transform row loads and box tests into the box culling
// block with random gaps, directed corner cases first and then mostly
// scene-like random traffic; the checker beside the block scores the results.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int         LATENCY    = 160;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         command;
    logic [2:0]         slot;
    logic signed [31:0] first_x, first_y, first_z, fourth;
    logic signed [31:0] second_x, second_y, second_z;
    logic               done;
    logic               visible;
    int                 fails;
    int                 pending;

    box_frustum_cull_test u_dut (.*);

    box_frustum_cull_checker u_chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("box_frustum_cull_test test failed");
        $finish;
    end

    // full range, scene scale, or an extreme
    function automatic logic signed [31:0] draw_value(input int scale);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 32'sh7fffffff;
        if (pick == 1)
            return 32'sh80000000;
        if (pick < 5 || scale == 0)
            return $urandom;
        return $signed($urandom_range(0, 2 * scale)) - scale;
    endfunction

    task automatic issue(input logic [1:0] cmd, input logic [2:0] sl,
        input logic signed [31:0] ax, input logic signed [31:0] ay,
        input logic signed [31:0] az, input logic signed [31:0] dw,
        input logic signed [31:0] bx, input logic signed [31:0] by,
        input logic signed [31:0] bz, input int gap);
        repeat (gap) @(negedge clk);
        command  = cmd;
        slot     = sl;
        first_x  = ax;
        first_y  = ay;
        first_z  = az;
        fourth   = dw;
        second_x = bx;
        second_y = by;
        second_z = bz;
        start    = 1'b1;
        while (busy)
            @(negedge clk);
        @(negedge clk);
        start = 1'b0;
    endtask

    task automatic random_request(input int gap);
        int                 kind;
        logic signed [31:0] q1;
        q1 = 32'sd1 <<< bfc_pkg::FRACTION_BITS;
        kind = $urandom_range(0, 99);
        if (kind < 20)
        begin
            if ($urandom_range(0, 1))
                issue(bfc_pkg::CMD_LOAD_PLANE, 3'($urandom_range(0, 7)),
                      ($urandom_range(0, 1) ? q1 : -q1) * $urandom_range(0, 1),
                      ($urandom_range(0, 1) ? q1 : -q1) * $urandom_range(0, 1),
                      ($urandom_range(0, 1) ? q1 : -q1) * $urandom_range(0, 1),
                      draw_value(1 << 22), $urandom, $urandom, $urandom, gap);
            else
                issue(bfc_pkg::CMD_LOAD_PLANE, 3'($urandom), draw_value(1 << 18),
                      draw_value(1 << 18), draw_value(1 << 18), draw_value(1 << 22),
                      $urandom, $urandom, $urandom, gap);
        end
        else if (kind < 30)
            issue(bfc_pkg::CMD_LOAD_ROW, 3'($urandom_range(0, 4)), draw_value(1 << 17),
                  draw_value(1 << 17), draw_value(1 << 17), draw_value(1 << 22),
                  $urandom, $urandom, $urandom, gap);
        else if (kind < 33)
            issue(CMD_UNUSED, 3'($urandom), $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, gap);
        else
            issue(bfc_pkg::CMD_TEST, 3'($urandom), draw_value(1 << 22),
                  draw_value(1 << 22), draw_value(1 << 22), $urandom,
                  draw_value(1 << 22), draw_value(1 << 22), draw_value(1 << 22), gap);
    endtask

    initial
    begin
        logic signed [31:0] one;
        logic signed [31:0] mx;
        logic signed [31:0] mn;
        int                 gap;
        bit                 calm;
        one = 32'sd1 <<< bfc_pkg::FRACTION_BITS;
        mx  = 32'sh7fffffff;
        mn  = 32'sh80000000;
        start    = 1'b0;
        command  = bfc_pkg::CMD_LOAD_PLANE;
        slot     = '0;
        first_x  = '0;
        first_y  = '0;
        first_z  = '0;
        fourth   = '0;
        second_x = '0;
        second_y = '0;
        second_z = '0;
        rst_n    = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset state: zero planes, identity transform
        issue(bfc_pkg::CMD_TEST, 3'd7, mn, mn, mn, mx, mx, mx, mx, 0);
        issue(bfc_pkg::CMD_TEST, 3'd0, -one, -one, -one, 0, one, one, one, 0);
        // near plane x >= 2.0, box behind then straddling
        issue(bfc_pkg::CMD_LOAD_PLANE, 3'd0, one, 0, 0, 2 * one, 0, 0, 0, 0);
        issue(bfc_pkg::CMD_TEST, 3'd0, -one, -one, -one, 0, one, one, one, 0);
        issue(bfc_pkg::CMD_TEST, 3'd5, -one, -one, -one, mn, 3 * one, one, one, 3);
        // corner exactly on the plane
        issue(bfc_pkg::CMD_TEST, 3'd1, -one, 0, 0, 0, 2 * one, 0, 0, 0);
        // ignored plane and row slots, unused command
        issue(bfc_pkg::CMD_LOAD_PLANE, 3'd6, -one, 0, 0, mx, 0, 0, 0, 0);
        issue(bfc_pkg::CMD_LOAD_PLANE, 3'd7, -one, 0, 0, mx, 0, 0, 0, 1);
        issue(bfc_pkg::CMD_LOAD_ROW, 3'd3, 0, 0, 0, mx, 0, 0, 0, 0);
        issue(bfc_pkg::CMD_LOAD_ROW, 3'd7, 0, 0, 0, mx, 0, 0, 0, 0);
        issue(CMD_UNUSED, 3'd0, mx, mx, mx, mx, mx, mx, mx, 0);
        // inverted box
        issue(bfc_pkg::CMD_TEST, 3'd2, 3 * one, one, one, 0, -one, -one, -one, 0);
        // translate x by 4.0 then saturate with extreme coefficients
        issue(bfc_pkg::CMD_LOAD_ROW, 3'd0, one, 0, 0, 4 * one, 0, 0, 0, 0);
        issue(bfc_pkg::CMD_TEST, 3'd0, -one, -one, -one, 0, one, one, one, 0);
        issue(bfc_pkg::CMD_LOAD_ROW, 3'd1, mx, mn, mx, mn, 0, 0, 0, 2);
        issue(bfc_pkg::CMD_LOAD_ROW, 3'd2, mn, mn, mn, mx, 0, 0, 0, 0);
        issue(bfc_pkg::CMD_LOAD_PLANE, 3'd5, mx, mn, mx, mn, 0, 0, 0, 0);
        issue(bfc_pkg::CMD_TEST, 3'd0, mx, mn, mx, 0, mn, mx, mn, 0);
        issue(bfc_pkg::CMD_TEST, 3'd0, mn, mn, mn, 0, mx, mx, mx, 0);
        issue(bfc_pkg::CMD_LOAD_PLANE, 3'd5, 0, 0, 0, 0, 0, 0, 0, 0);
        for (int r = 0; r < bfc_pkg::NUM_ROWS; r++)
            issue(bfc_pkg::CMD_LOAD_ROW, 3'(r), r == 0 ? one : 0, r == 1 ? one : 0,
                  r == 2 ? one : 0, 0, 0, 0, 0, 0);

        // hold off until every result is in
        while (pending != 0)
            @(negedge clk);

        calm = 1'b0;
        for (int i = 0; i < 1930; i++)
        begin
            if (i % 100 == 0)
                calm = ($urandom_range(0, 3) == 0);
            gap = calm ? 0 : $urandom_range(0, 14);
            random_request(gap);
            if (i == 1000)
            begin
                while (pending != 0)
                    @(negedge clk);
            end
        end

        while (pending != 0)
            @(negedge clk);
        repeat (LATENCY) @(negedge clk);
        if (fails == 0)
            $display("box_frustum_cull_test test passed");
        else
            $display("box_frustum_cull_test test failed");
        $finish;
    end

endmodule
